// ===== rtl/bpes_pkg.sv =====
`timescale 1ns / 1ps
// Package for the band peak envelope smoother.
// Holds register indexes, reset values, the sequencer state type and saturation.
package bpes_pkg;

  localparam int unsigned CFG_W    = 17;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned SAT_W    = 36;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ALPHA_RISE = 3'd0,
    REG_ALPHA_FALL = 3'd1,
    REG_FALL_STEP  = 3'd2,
    REG_RISE_LAG   = 3'd3,
    REG_RAW_SCALE  = 3'd4
  } cfg_reg_e;

  localparam logic [16:0]        ALPHA_RISE_RST = 17'd18558;
  localparam logic [16:0]        ALPHA_FALL_RST = 17'd2376;
  localparam logic signed [16:0] FALL_STEP_RST  = -17'sd162;
  localparam logic signed [16:0] RISE_LAG_RST   = -17'sd5783;
  localparam logic [15:0]        RAW_SCALE_RST  = 16'd2080;
  localparam logic [16:0]        ALPHA_ONE      = 17'h10000;

  typedef enum logic [1:0] {
    S_IDLE,
    S_MUL1,
    S_MUL2,
    S_OUT
  } state_e;

  function automatic logic signed [31:0] sat32(input logic signed [SAT_W-1:0] x);
    logic all_one;
    logic any_one;
    all_one = &x[SAT_W-1:31];
    any_one = |x[SAT_W-1:31];
    if (all_one || !any_one) begin
      return x[31:0];
    end
    return x[SAT_W-1] ? 32'sh8000_0000 : 32'sh7fff_ffff;
  endfunction

endpackage

// ===== rtl/band_peak_envelope_smoother.sv =====
`timescale 1ns / 1ps
// Band peak envelope smoother: running channel maximum and per-band asymmetric smoothing.
// Depends on bpes_pkg. One shared multiplier is sequenced over both products.
// Sequence: a taken closing transaction steps through S_MUL1, S_MUL2 and S_OUT; the result
// is registered onto m_axis from S_OUT. s_axis_tready stays low until then, over the two
// passes through the shared multiplier; other transactions are taken every cycle while idle.
// Reset clears configuration to defaults, the channel maximum and the per-band valid bits,
// so every band level reads as zero after reset; there is no clearing pass.
module band_peak_envelope_smoother import bpes_pkg::*; #(
  parameter int unsigned BANDS = 32
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,   // [4:0] band, [36:5] level, upper bits zero
  input  logic        s_axis_tuser,   // first_channel
  input  logic        s_axis_tlast,   // last_channel
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // [4:0] out_band, [36:5] smoothed, [68:37] raw_level
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam int unsigned IDX_W = (BANDS > 1) ? $clog2(BANDS) : 1;

  logic [16:0]        alpha_rise_q;
  logic [16:0]        alpha_fall_q;
  logic signed [16:0] fall_step_q;
  logic signed [16:0] rise_lag_q;
  logic [15:0]        raw_scale_q;

  state_e state_q, state_d;

  logic [4:0]         in_band;
  logic signed [31:0] in_level;
  logic               in_fire;
  logic               in_update;
  logic [IDX_W-1:0]   in_idx;

  logic signed [31:0] chmax_q;
  logic [4:0]         band_q;
  logic [IDX_W-1:0]   idx_q;
  logic signed [31:0] rd_q;
  logic [BANDS-1:0]   vld_q;
  logic signed [31:0] mem [BANDS];

  logic signed [31:0] prev;
  logic               fall;
  logic [16:0]        alpha_sel;
  logic [16:0]        alpha_clamp;
  logic signed [32:0] diff;
  logic signed [32:0] lim_sum;
  logic signed [31:0] prev_q, lim_q;

  logic signed [32:0] mul_a;
  logic signed [17:0] mul_b;
  logic signed [50:0] mul_p;
  logic signed [50:0] prod_q;

  logic signed [31:0] wgt;
  logic signed [31:0] nxt;
  logic signed [31:0] nxt_q;
  logic signed [31:0] raw;

  logic               out_vld_q;
  logic [71:0]        out_data_q;
  logic               out_load;

  assign in_band   = s_axis_tdata[4:0];
  assign in_level  = $signed(s_axis_tdata[36:5]);
  assign in_fire   = s_axis_tvalid && s_axis_tready;
  assign in_update = s_axis_tlast && (32'(in_band) < BANDS);
  assign in_idx    = IDX_W'(in_band);
  assign s_axis_tready = (state_q == S_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      alpha_rise_q <= ALPHA_RISE_RST;
      alpha_fall_q <= ALPHA_FALL_RST;
      fall_step_q  <= FALL_STEP_RST;
      rise_lag_q   <= RISE_LAG_RST;
      raw_scale_q  <= RAW_SCALE_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_ALPHA_RISE: alpha_rise_q <= cfg_data_i;
        REG_ALPHA_FALL: alpha_fall_q <= cfg_data_i;
        REG_FALL_STEP:  fall_step_q  <= $signed(cfg_data_i);
        REG_RISE_LAG:   rise_lag_q   <= $signed(cfg_data_i);
        REG_RAW_SCALE:  raw_scale_q  <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chmax_q <= '0;
    end else if (in_fire && (s_axis_tuser || (in_level > chmax_q))) begin
      chmax_q <= in_level;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      rd_q   <= mem[in_idx];
      band_q <= in_band;
      idx_q  <= in_idx;
    end
    if (state_q == S_MUL2) begin
      mem[idx_q] <= nxt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (state_q == S_MUL2) begin
      vld_q[idx_q] <= 1'b1;
    end
  end

  assign prev        = vld_q[idx_q] ? rd_q : '0;
  assign fall        = chmax_q < prev;
  assign alpha_sel   = fall ? alpha_fall_q : alpha_rise_q;
  assign alpha_clamp = (alpha_sel > ALPHA_ONE) ? ALPHA_ONE : alpha_sel;
  assign diff        = 33'(chmax_q) - 33'(prev);
  assign lim_sum     = fall ? (33'(prev) + 33'(fall_step_q)) : (33'(chmax_q) + 33'(rise_lag_q));

  always_comb begin
    if (state_q == S_MUL1) begin
      mul_a = diff;
      mul_b = $signed({1'b0, alpha_clamp});
    end else begin
      mul_a = 33'(nxt);
      mul_b = $signed({2'b00, raw_scale_q});
    end
  end

  assign mul_p = 51'(mul_a) * 51'(mul_b);

  assign wgt = sat32(SAT_W'(prev_q) + SAT_W'($signed(prod_q[50:16])));
  assign nxt = (lim_q > wgt) ? lim_q : wgt;
  assign raw = sat32(SAT_W'($signed(prod_q[50:16])));

  always_ff @(posedge clk_i) begin
    if (state_q == S_MUL1) begin
      prev_q <= prev;
      lim_q  <= sat32(SAT_W'(lim_sum));
    end
    if (state_q == S_MUL1 || state_q == S_MUL2) begin
      prod_q <= mul_p;
    end
    if (state_q == S_MUL2) begin
      nxt_q <= nxt;
    end
  end

  assign out_load = (state_q == S_OUT) && (!out_vld_q || m_axis_tready);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_fire && in_update) begin
          state_d = S_MUL1;
        end
      end
      S_MUL1:  state_d = S_MUL2;
      S_MUL2:  state_d = S_OUT;
      S_OUT: begin
        if (out_load) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (out_load) begin
      out_vld_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_data_q <= {3'b000, raw, nxt_q, band_q};
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_data_q;

endmodule

// ===== rtl/bpes_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the band peak envelope smoother, bound to the top level.
// Sees only the top-level ports; no package dependency.
module bpes_checker #(
  parameter int unsigned BANDS = 32
) (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [39:0] s_axis_tdata,
  input logic        s_axis_tuser,
  input logic        s_axis_tlast,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [71:0] m_axis_tdata
);

  logic in_fire;
  logic closes;

  assign in_fire = s_axis_tvalid && s_axis_tready;
  assign closes  = s_axis_tlast && (32'(s_axis_tdata[4:0]) < BANDS);

  a_busy_after_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && closes |=> !s_axis_tready)
    else $error("block still ready after a band-closing transaction");

  a_ready_after_plain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire && !closes |=> s_axis_tready)
    else $error("block stalled after a transaction that closes no band");

  a_result_from_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> $past(!s_axis_tready))
    else $error("result appeared without a band update in progress");

  a_band_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[4:0]) < BANDS))
    else $error("result carries a band outside the store");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed or was dropped");

endmodule

bind band_peak_envelope_smoother bpes_checker #(.BANDS(BANDS)) u_bpes_checker (.*);
